/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL files of the execute block.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define TMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset as well.
`define TMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tmm_pkg.sv */
// Shared types, opcodes and helpers of the toy machine execute block.
// No dependencies.
package tmm_pkg;

  localparam int MEM_DEPTH = 16;
  localparam int ADDR_W    = 4;
  localparam int MODE_W    = 4;
  localparam int IO_W      = 32;

  localparam logic [MODE_W-1:0] OP_HALT  = 4'd0;
  localparam logic [MODE_W-1:0] OP_LOAD  = 4'd1;
  localparam logic [MODE_W-1:0] OP_SAVE  = 4'd2;
  localparam logic [MODE_W-1:0] OP_ADD   = 4'd3;
  localparam logic [MODE_W-1:0] OP_SUB   = 4'd4;
  localparam logic [MODE_W-1:0] OP_GT    = 4'd5;
  localparam logic [MODE_W-1:0] OP_LT    = 4'd6;
  localparam logic [MODE_W-1:0] OP_EQ    = 4'd7;
  localparam logic [MODE_W-1:0] OP_IF    = 4'd8;
  localparam logic [MODE_W-1:0] OP_IN    = 4'd9;
  localparam logic [MODE_W-1:0] OP_OUT   = 4'd10;
  localparam logic [MODE_W-1:0] OP_GOTO  = 4'd11;
  localparam logic [MODE_W-1:0] OP_PERS  = 4'd12;
  localparam logic [MODE_W-1:0] OP_RELD  = 4'd13;
  localparam logic [MODE_W-1:0] OP_CONST = 4'd14;
  localparam logic [MODE_W-1:0] OP_MOVE  = 4'd15;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [MODE_W-1:0] mode_t;

  // Control side of one executed instruction.
  typedef struct packed {
    logic  wm_we;
    addr_t wm_addr;
    logic  bs_we;
    addr_t bs_addr;
    logic  set_halt;
    logic  print_valid;
    logic  jump_valid;
    addr_t jump_target;
  } exec_ctl_t;

  // Opcodes whose first working-memory read is at operand a instead of b.
  function automatic logic reads_a(input mode_t m);
    logic r;
    begin
      r = (m == OP_SAVE) || (m == OP_IF) || (m == OP_OUT) || (m == OP_MOVE);
      return r;
    end
  endfunction

endpackage

/* rtl/core/tmm_if.sv */
// Valid/ready channel interfaces for instructions and results.
// Depends on tmm_pkg.
interface tmm_in_if import tmm_pkg::*; ();
  logic               valid;
  logic               ready;
  mode_t              mode;
  addr_t              operand_a;
  addr_t              operand_b;
  addr_t              operand_c;
  logic signed [31:0] input_value;

  modport source (output valid, mode, operand_a, operand_b, operand_c, input_value,
                  input ready);
  modport sink   (input valid, mode, operand_a, operand_b, operand_c, input_value,
                  output ready);
endinterface

interface tmm_out_if import tmm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               halted;
  logic               print_valid;
  logic signed [31:0] print_value;
  logic               jump_valid;
  addr_t              jump_target;

  modport source (output valid, halted, print_valid, print_value, jump_valid, jump_target,
                  input ready);
  modport sink   (input valid, halted, print_valid, print_value, jump_valid, jump_target,
                  output ready);
endinterface

/* rtl/core/tmm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/tmm_alu.sv */
// Opcode decode and datapath for one instruction: write request and result fields.
// Depends on tmm_pkg.
module tmm_alu import tmm_pkg::*; #(
  parameter int WORD_W = 32
) (
  input  mode_t              mode,
  input  addr_t              opa,
  input  addr_t              opb,
  input  addr_t              opc,
  input  logic [WORD_W-1:0]  in_word,
  input  logic [WORD_W-1:0]  x,       // work[a] or work[b], per reads_a()
  input  logic [WORD_W-1:0]  y,       // work[c]
  input  logic [WORD_W-1:0]  bs,      // store[a]
  output exec_ctl_t          ctl,
  output logic [WORD_W-1:0]  wr_data,
  output logic signed [IO_W-1:0] print_value
);

  localparam logic [WORD_W-1:0] ONE = WORD_W'(1);

  always_comb begin
    ctl         = '0;
    wr_data     = '0;
    print_value = '0;
    ctl.wm_addr = opa;
    ctl.bs_addr = opb;
    case (mode)
      OP_HALT: ctl.set_halt = 1'b1;
      OP_LOAD: begin
        ctl.wm_we   = 1'b1;
        ctl.wm_addr = opb;
        wr_data     = bs;
      end
      OP_SAVE: begin
        ctl.bs_we = 1'b1;
        wr_data   = x;
      end
      OP_ADD: begin
        ctl.wm_we = 1'b1;
        wr_data   = x + y;
      end
      OP_SUB: begin
        ctl.wm_we = 1'b1;
        wr_data   = x - y;
      end
      OP_GT: begin
        ctl.wm_we = 1'b1;
        wr_data   = ($signed(x) > $signed(y)) ? ONE : '0;
      end
      OP_LT: begin
        ctl.wm_we = 1'b1;
        wr_data   = ($signed(x) < $signed(y)) ? ONE : '0;
      end
      OP_EQ: begin
        ctl.wm_we = 1'b1;
        wr_data   = (x == y) ? ONE : '0;
      end
      OP_IF: begin
        ctl.jump_valid  = 1'b1;
        ctl.jump_target = (x != '0) ? opb : opc;
      end
      OP_IN: begin
        ctl.wm_we = 1'b1;
        wr_data   = in_word;
      end
      OP_OUT: begin
        ctl.print_valid = 1'b1;
        print_value     = IO_W'($signed(x));
      end
      OP_GOTO: begin
        ctl.jump_valid  = 1'b1;
        ctl.jump_target = opa;
      end
      OP_CONST: begin
        ctl.wm_we   = 1'b1;
        ctl.wm_addr = opb;
        wr_data     = WORD_W'(opa);
      end
      OP_MOVE: begin
        ctl.wm_we   = 1'b1;
        ctl.wm_addr = opb;
        wr_data     = x;
      end
      default: ;  // persist / reload: no effect
    endcase
  end

endmodule

/* rtl/core/toy_memory_machine_execute.sv */
// Top level of the toy machine execute block: read stage, execute stage, result register.
// Depends on tmm_pkg, tmm_if, tmm_ram, tmm_alu and assert_macros.svh.
//
// One decoded instruction is taken per beat and one result beat comes out for
// each, in order. Throughput is one instruction per clock while the result side
// keeps ready high; a stall there holds input ready low. The stages follow
// from the registered read of the memories: operands are read at the accept
// edge, the execute stage does the add/compare and the write-back, and the result
// lands in the output register. A write-back in the same cycle that a new beat
// reads is forwarded to it, so dependent instructions may follow back to back.
// Both memories read as zero after reset through per-entry valid bits; no
// clearing pass is needed. Halt is sticky until reset; later instructions
// still execute.
module toy_memory_machine_execute import tmm_pkg::*; #(
  parameter int WORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  tmm_in_if.sink    in_ch,
  tmm_out_if.source out_ch
);

`include "assert_macros.svh"

  typedef logic [WORD_WIDTH-1:0] word_t;

  // ---------------------------------------------------------------
  // Handshake: execute stage drains into the result register.
  // ---------------------------------------------------------------
  logic ex_vld_r;
  logic out_vld_r;
  logic out_free;
  logic ex_go;
  logic in_rdy;
  logic in_fire;

  assign out_free = !out_vld_r || out_ch.ready;
  assign ex_go    = ex_vld_r && out_free;
  assign in_rdy   = !ex_vld_r || out_free;
  assign in_fire  = in_ch.valid && in_rdy;
  assign in_ch.ready = in_rdy;

  // ---------------------------------------------------------------
  // Read addresses from the incoming beat
  // ---------------------------------------------------------------
  addr_t rd0;
  assign rd0 = reads_a(in_ch.mode) ? in_ch.operand_a : in_ch.operand_b;

  // ---------------------------------------------------------------
  // Execute stage registers (payload, no reset)
  // ---------------------------------------------------------------
  mode_t ex_mode_r;
  addr_t ex_a_r, ex_b_r, ex_c_r;
  word_t ex_iv_r;

  // valid bit of the entry read, forward flags and forwarded word
  logic  v0_r, v1_r, vb_r;
  logic  fw0_r, fw1_r, fwb_r;
  word_t fw_data_r;

  exec_ctl_t ctl;
  word_t     wr_data;
  logic signed [IO_W-1:0] print_value;

  logic wm_we, bs_we;
  assign wm_we = ex_go && ctl.wm_we;
  assign bs_we = ex_go && ctl.bs_we;

  logic fw0, fw1, fwb;
  assign fw0 = wm_we && (ctl.wm_addr == rd0);
  assign fw1 = wm_we && (ctl.wm_addr == in_ch.operand_c);
  assign fwb = bs_we && (ctl.bs_addr == in_ch.operand_a);

  // ---------------------------------------------------------------
  // Valid bits: an entry never written reads as zero
  // ---------------------------------------------------------------
  logic [MEM_DEPTH-1:0] wvld_r, bvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= '0;
      bvld_r <= '0;
    end else begin
      if (wm_we) begin
        wvld_r[ctl.wm_addr] <= 1'b1;
      end
      if (bs_we) begin
        bvld_r[ctl.bs_addr] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------
  // Memories: working memory duplicated for its two read ports
  // ---------------------------------------------------------------
  word_t q0, q1, qb;

  tmm_ram #(.WIDTH(WORD_WIDTH), .DEPTH(MEM_DEPTH)) u_wm0 (
    .clk   (clk),
    .we    (wm_we),
    .waddr (ctl.wm_addr),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (rd0),
    .rdata (q0)
  );

  tmm_ram #(.WIDTH(WORD_WIDTH), .DEPTH(MEM_DEPTH)) u_wm1 (
    .clk   (clk),
    .we    (wm_we),
    .waddr (ctl.wm_addr),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (in_ch.operand_c),
    .rdata (q1)
  );

  tmm_ram #(.WIDTH(WORD_WIDTH), .DEPTH(MEM_DEPTH)) u_bs (
    .clk   (clk),
    .we    (bs_we),
    .waddr (ctl.bs_addr),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (in_ch.operand_a),
    .rdata (qb)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_mode_r <= in_ch.mode;
      ex_a_r    <= in_ch.operand_a;
      ex_b_r    <= in_ch.operand_b;
      ex_c_r    <= in_ch.operand_c;
      ex_iv_r   <= WORD_WIDTH'(in_ch.input_value);  // sign-extend or cut
      v0_r      <= wvld_r[rd0];
      v1_r      <= wvld_r[in_ch.operand_c];
      vb_r      <= bvld_r[in_ch.operand_a];
      fw0_r     <= fw0;
      fw1_r     <= fw1;
      fwb_r     <= fwb;
      fw_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_vld_r <= 1'b0;
    end else if (in_rdy) begin
      ex_vld_r <= in_ch.valid;
    end
  end

  // Operand words: forwarded write wins, then RAM if written, else zero.
  word_t x, y, bs;
  assign x  = fw0_r ? fw_data_r : (v0_r ? q0 : '0);
  assign y  = fw1_r ? fw_data_r : (v1_r ? q1 : '0);
  assign bs = fwb_r ? fw_data_r : (vb_r ? qb : '0);

  tmm_alu #(.WORD_W(WORD_WIDTH)) u_alu (
    .mode        (ex_mode_r),
    .opa         (ex_a_r),
    .opb         (ex_b_r),
    .opc         (ex_c_r),
    .in_word     (ex_iv_r),
    .x           (x),
    .y           (y),
    .bs          (bs),
    .ctl         (ctl),
    .wr_data     (wr_data),
    .print_value (print_value)
  );

  // ---------------------------------------------------------------
  // Sticky halt and result register
  // ---------------------------------------------------------------
  logic halt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_r <= 1'b0;
    end else if (ex_go && ctl.set_halt) begin
      halt_r <= 1'b1;
    end
  end

  logic                   o_halted_r;
  logic                   o_pv_r;
  logic signed [IO_W-1:0] o_pval_r;
  logic                   o_jv_r;
  addr_t                  o_jt_r;

  always_ff @(posedge clk) begin
    if (ex_go) begin
      o_halted_r <= halt_r || ctl.set_halt;
      o_pv_r     <= ctl.print_valid;
      o_pval_r   <= print_value;
      o_jv_r     <= ctl.jump_valid;
      o_jt_r     <= ctl.jump_target;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= ex_vld_r;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.halted      = o_halted_r;
  assign out_ch.print_valid = o_pv_r;
  assign out_ch.print_value = o_pval_r;
  assign out_ch.jump_valid  = o_jv_r;
  assign out_ch.jump_target = o_jt_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `TMM_ASSERT(a_go_fills_out, ex_go |=> out_vld_r, "executed beat did not reach result reg")
  `TMM_ASSERT(a_halt_sticky, halt_r |=> halt_r, "halt flag dropped")
  `TMM_ASSERT(a_halt_in_result, (halt_r && out_vld_r) |-> o_halted_r, "result misses halt")
  `TMM_ASSERT(a_print_jump_excl, out_vld_r |-> !(o_pv_r && o_jv_r), "print and jump together")

endmodule

/* dv/tmm_exec_checker.sv */
`timescale 1ns / 100ps
// Result checker for the toy machine execute block: keeps its own copy of both memories
// and the halt flag, predicts every result beat and compares them in order.
// Depends on tmm_pkg and the channel interfaces in tmm_if.
module tmm_exec_checker import tmm_pkg::*; #(
  parameter int WORD_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  tmm_in_if    in_mon,
  tmm_out_if   out_mon,
  output int   mismatch_count,
  output int   results_owed
);

  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef struct packed {
    logic        halted;
    logic        print_valid;
    logic [31:0] print_value;
    logic        jump_valid;
    addr_t       jump_target;
  } instr_result_t;

  word_t         work_mem  [MEM_DEPTH];
  word_t         store_mem [MEM_DEPTH];
  logic          halt_seen;
  instr_result_t instr_results_q [$];
  int            result_idx;

  task automatic report_mismatch(input string what);
    $display("%0t ns: result %0d: %s", $time, result_idx, what);
    mismatch_count++;
  endtask

  // Executes one instruction on the shadow state and returns the result it reports.
  function automatic instr_result_t execute_instr(input mode_t op, input addr_t a,
                                                  input addr_t b, input addr_t c,
                                                  input logic signed [31:0] iv);
    instr_result_t r;
    word_t         x;
    word_t         y;
    r = '0;
    x = work_mem[b];
    y = work_mem[c];
    case (op)
      OP_HALT:  halt_seen = 1'b1;
      OP_LOAD:  work_mem[b] = store_mem[a];
      OP_SAVE:  store_mem[b] = work_mem[a];
      OP_ADD:   work_mem[a] = x + y;
      OP_SUB:   work_mem[a] = x - y;
      OP_GT:    work_mem[a] = word_t'($signed(x) > $signed(y));
      OP_LT:    work_mem[a] = word_t'($signed(x) < $signed(y));
      OP_EQ:    work_mem[a] = word_t'(x == y);
      OP_IF: begin
        r.jump_valid  = 1'b1;
        r.jump_target = (work_mem[a] != '0) ? b : c;
      end
      OP_IN:    work_mem[a] = word_t'(iv);  // sign-extends or truncates
      OP_OUT: begin
        r.print_valid = 1'b1;
        r.print_value = 32'($signed(work_mem[a]));
      end
      OP_GOTO: begin
        r.jump_valid  = 1'b1;
        r.jump_target = a;
      end
      OP_PERS, OP_RELD: ;
      OP_CONST: work_mem[b] = word_t'(a);
      OP_MOVE:  work_mem[b] = work_mem[a];
      default: ;
    endcase
    r.halted = halt_seen;
    return r;
  endfunction

  task automatic check_result();
    instr_result_t want;
    if (instr_results_q.size() == 0) begin
      report_mismatch("result beat with no instruction outstanding");
    end else begin
      want = instr_results_q.pop_front();
      if (out_mon.halted !== want.halted)
        report_mismatch($sformatf("halted expected %b got %b", want.halted, out_mon.halted));
      if (out_mon.print_valid !== want.print_valid)
        report_mismatch($sformatf("print_valid expected %b got %b",
                                  want.print_valid, out_mon.print_valid));
      if (out_mon.print_value !== want.print_value)
        report_mismatch($sformatf("print_value expected %h got %h",
                                  want.print_value, out_mon.print_value));
      if (out_mon.jump_valid !== want.jump_valid)
        report_mismatch($sformatf("jump_valid expected %b got %b",
                                  want.jump_valid, out_mon.jump_valid));
      if (out_mon.jump_target !== want.jump_target)
        report_mismatch($sformatf("jump_target expected %h got %h",
                                  want.jump_target, out_mon.jump_target));
    end
    result_idx++;
  endtask

  // Result beats are handled before instruction beats of the same edge: a result can
  // never belong to an instruction accepted at that very edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MEM_DEPTH; i++) begin
        work_mem[i]  = '0;
        store_mem[i] = '0;
      end
      halt_seen = 1'b0;
      instr_results_q.delete();
      result_idx     = 0;
      mismatch_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready)
        check_result();
      if (in_mon.valid && in_mon.ready)
        instr_results_q.push_back(execute_instr(in_mon.mode, in_mon.operand_a,
                                                in_mon.operand_b, in_mon.operand_c,
                                                in_mon.input_value));
    end
    results_owed <= instr_results_q.size();
  end

endmodule

/* dv/tb_toy_memory_machine_execute.sv */
`timescale 1ns / 100ps
// Testbench top for the toy machine execute block: clock, reset, instruction stimulus,
// result-side stalls, watchdog and verdict. Depends on tmm_pkg, tmm_if and tmm_exec_checker.
module tb_toy_memory_machine_execute;
  import tmm_pkg::*;

  localparam int WORD_WIDTH   = 32;
  localparam int RANDOM_ITEMS = 1250;
  localparam int BLOCK_ITEMS  = 50;    // items per random block sharing one gap/address style
  localparam int SYNC_ITEMS   = 250;   // sender waits for all results this often
  localparam int IDLE_LIMIT   = 2000;  // well above the longest gap or stall
  localparam int DRAIN_CYCLES = 4;

  logic clk;
  logic rst_n;
  logic calm;            // no gaps on either side while set
  int   mismatch_count;
  int   results_owed;
  int   idle_cycles = 0;

  tmm_in_if  in_ch ();
  tmm_out_if out_ch ();

  toy_memory_machine_execute #(.WORD_WIDTH(WORD_WIDTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tmm_exec_checker #(.WORD_WIDTH(WORD_WIDTH)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm)
      return 0;
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Narrow addressing keeps traffic on four words so results feed each other.
  function automatic addr_t pick_addr(input logic narrow);
    if (narrow)
      return addr_t'($urandom_range(0, 3));
    return addr_t'($urandom_range(0, MEM_DEPTH - 1));
  endfunction

  // Word extremes and small values are common; the rest is uniform.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      4: return 32'($urandom_range(0, 20));
      5: return -32'($urandom_range(1, 20));
      default: return $urandom();
    endcase
  endfunction

  // One instruction beat. valid stays high into the next call when it has no gap,
  // so valid never gets two assignments in one step.
  task automatic send_instr(input mode_t op, input addr_t a, input addr_t b, input addr_t c,
                            input logic [31:0] iv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= op;
    in_ch.operand_a   <= a;
    in_ch.operand_b   <= b;
    in_ch.operand_c   <= c;
    in_ch.input_value <= iv;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Sender holds off until every outstanding result has come back. results_owed is
  // a register the checker updates at each edge, so the sender waits on the clock first.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Result side: ready drops for random stretches, never while calm.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: ends the run after too many cycles with no beat on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    mode_t op;
    logic  narrow;
    calm              = 1'b1;
    narrow            = 1'b0;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= OP_HALT;
    in_ch.operand_a   <= '0;
    in_ch.operand_b   <= '0;
    in_ch.operand_c   <= '0;
    in_ch.input_value <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, back to back so dependent instructions hit the forwarding path.
    // Word extremes into memory, then wrap on add and sub, signed compares.
    send_instr(OP_OUT,   4'd13, 4'd0,  4'd0,  $urandom());     // untouched word reads zero
    send_instr(OP_IN,    4'd0,  4'd0,  4'd0,  32'h7FFF_FFFF);
    send_instr(OP_IN,    4'd15, 4'd0,  4'd0,  32'h8000_0000);
    send_instr(OP_IN,    4'd1,  4'd0,  4'd0,  32'hFFFF_FFFF);
    send_instr(OP_ADD,   4'd2,  4'd0,  4'd0,  $urandom());     // max + max wraps
    send_instr(OP_SUB,   4'd3,  4'd15, 4'd0,  $urandom());     // min - max wraps
    send_instr(OP_GT,    4'd4,  4'd0,  4'd15, $urandom());     // max > min signed
    send_instr(OP_LT,    4'd5,  4'd0,  4'd15, $urandom());
    send_instr(OP_EQ,    4'd6,  4'd1,  4'd1,  $urandom());
    send_instr(OP_EQ,    4'd7,  4'd0,  4'd1,  $urandom());
    send_instr(OP_OUT,   4'd2,  4'd9,  4'd9,  $urandom());
    send_instr(OP_OUT,   4'd15, 4'd0,  4'd0,  $urandom());
    send_instr(OP_IF,    4'd6,  4'd15, 4'd0,  $urandom());     // taken
    send_instr(OP_IF,    4'd7,  4'd3,  4'd9,  $urandom());     // falls to c
    send_instr(OP_GOTO,  4'd15, 4'd5,  4'd6,  $urandom());
    send_instr(OP_CONST, 4'd15, 4'd8,  4'd0,  $urandom());
    send_instr(OP_CONST, 4'd0,  4'd9,  4'd0,  $urandom());
    send_instr(OP_MOVE,  4'd15, 4'd10, 4'd0,  $urandom());
    send_instr(OP_SAVE,  4'd0,  4'd15, 4'd0,  $urandom());
    send_instr(OP_LOAD,  4'd15, 4'd11, 4'd0,  $urandom());
    send_instr(OP_LOAD,  4'd3,  4'd12, 4'd0,  $urandom());     // never-saved store entry
    send_instr(OP_PERS,  4'd5,  4'd6,  4'd7,  $urandom());     // no-op opcodes
    send_instr(OP_RELD,  4'd10, 4'd11, 4'd12, $urandom());
    send_instr(OP_OUT,   4'd11, 4'd0,  4'd0,  $urandom());
    send_instr(OP_HALT,  4'd1,  4'd2,  4'd3,  $urandom());
    send_instr(OP_OUT,   4'd8,  4'd0,  4'd0,  $urandom());     // still runs after halt
    wait_results_drained();

    // Random part: each block picks at random calm or gappy traffic and narrow or
    // full addressing; every SYNC_ITEMS the sender waits for the results.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK_ITEMS == 0) begin
        calm   = ($urandom_range(0, 3) == 0);
        narrow = ($urandom_range(0, 2) == 0);
      end
      if (n > 0 && n % SYNC_ITEMS == 0)
        wait_results_drained();
      op = mode_t'($urandom_range(0, 15));
      if ($urandom_range(0, 4) == 0)
        op = OP_IN;  // keep fresh values flowing into memory
      send_instr(op, pick_addr(narrow), pick_addr(narrow), pick_addr(narrow), pick_value());
    end

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/tmm_pkg.sv
rtl/core/tmm_if.sv
rtl/core/tmm_ram.sv
rtl/core/tmm_alu.sv
rtl/core/toy_memory_machine_execute.sv
dv/tmm_exec_checker.sv
dv/tb_toy_memory_machine_execute.sv
